### src/mcr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Midpoint circle rasteriser package
// Shared widths, codes and the step word passed from the step unit to the
// pixel serialiser.
// ----------------------------------------------------------------------------
package mcr_pkg;

	localparam int COORD_BITS  = 10;
	localparam int RADIUS_BITS = 8;
	localparam int PIX_W       = 12;
	localparam int COLOUR_W    = 8;
	localparam int MIRROR_W    = 3;

	localparam logic [MIRROR_W-1:0] MIRROR_LAST = 3'd7;
	localparam logic [COLOUR_W-1:0] FULL_ALPHA  = 8'hFF;

	localparam logic MODE_START    = 1'b0;
	localparam logic MODE_CONTINUE = 1'b1;

	typedef struct packed {
		logic                idle;
		logic                finished;
		logic [PIX_W-1:0]    maj;
		logic [PIX_W-1:0]    mnr;
		logic [PIX_W-1:0]    cx;
		logic [PIX_W-1:0]    cy;
		logic [COLOUR_W-1:0] red;
		logic [COLOUR_W-1:0] green;
		logic [COLOUR_W-1:0] blue;
		logic [COLOUR_W-1:0] alpha;
	} step_t;

endpackage
`default_nettype wire

### src/mcr_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Midpoint circle step unit
// Holds the circle state, applies the octant step rule on each accepted word
// and presents the offsets to mirror for that word.
// ----------------------------------------------------------------------------
module mcr_step #(
	parameter int COORD_BITS  = mcr_pkg::COORD_BITS,
	parameter int RADIUS_BITS = mcr_pkg::RADIUS_BITS
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               accept,
	input  wire logic                               mode,
	input  wire logic [COORD_BITS-1:0]              center_x,
	input  wire logic [COORD_BITS-1:0]              center_y,
	input  wire logic [RADIUS_BITS-1:0]             radius,
	input  wire logic [mcr_pkg::COLOUR_W-1:0]       red,
	input  wire logic [mcr_pkg::COLOUR_W-1:0]       green,
	input  wire logic [mcr_pkg::COLOUR_W-1:0]       blue,
	input  wire logic [mcr_pkg::COLOUR_W-1:0]       alpha,
	input  wire logic                               outline_only,
	output mcr_pkg::step_t                          step
);

	localparam int OFS_W = RADIUS_BITS + 2;
	localparam int ERR_W = RADIUS_BITS + 4;

	logic                          busy_q;
	logic [COORD_BITS-1:0]         cx_q, cy_q;
	logic [RADIUS_BITS-1:0]        ring_q;
	logic signed [OFS_W-1:0]       maj_q, min_q;
	logic signed [ERR_W-1:0]       err_q;
	logic [mcr_pkg::COLOUR_W-1:0]  red_q, green_q, blue_q, alpha_q;
	logic                          outline_q;

	logic                          start, small_fill, idle_out;
	logic [COORD_BITS-1:0]         cx0, cy0;
	logic [RADIUS_BITS-1:0]        rr0, rr_dec;
	logic signed [OFS_W-1:0]       maj0, min0, min1, maj2;
	logic signed [ERR_W-1:0]       err0, err1, err2, inc_min, dec_maj;
	logic [mcr_pkg::COLOUR_W-1:0]  red0, green0, blue0, alpha0;
	logic                          outline0, wrap, finished;

	always_comb begin
		start      = (mode == mcr_pkg::MODE_START);
		small_fill = start && !outline_only && (radius < RADIUS_BITS'(2));
		idle_out   = small_fill || (!start && !busy_q);
		if (start) begin
			cx0      = center_x;
			cy0      = center_y;
			rr0      = radius;
			maj0     = $signed({2'b00, radius});
			min0     = '0;
			err0     = '0;
			red0     = red;
			green0   = green;
			blue0    = blue;
			alpha0   = alpha;
			outline0 = outline_only;
		end else begin
			cx0      = cx_q;
			cy0      = cy_q;
			rr0      = ring_q;
			maj0     = maj_q;
			min0     = min_q;
			err0     = err_q;
			red0     = red_q;
			green0   = green_q;
			blue0    = blue_q;
			alpha0   = alpha_q;
			outline0 = outline_q;
		end
	end

	always_comb begin
		if (err0[ERR_W-1] || (err0 == '0)) begin
			min1 = min0 + OFS_W'(1);
		end else begin
			min1 = min0;
		end
		inc_min = ERR_W'($signed({min1, 1'b1}));
		if (err0[ERR_W-1] || (err0 == '0)) begin
			err1 = err0 + inc_min;
		end else begin
			err1 = err0;
		end
		if (!err1[ERR_W-1] && (err1 != '0)) begin
			maj2 = maj0 - OFS_W'(1);
		end else begin
			maj2 = maj0;
		end
		dec_maj = ERR_W'($signed({maj2, 1'b1}));
		if (!err1[ERR_W-1] && (err1 != '0)) begin
			err2 = err1 - dec_maj;
		end else begin
			err2 = err1;
		end
		wrap     = (maj2 < min1);
		finished = wrap && (outline0 || (rr0 < RADIUS_BITS'(3)));
		rr_dec   = rr0 - RADIUS_BITS'(1);
	end

	always_comb begin
		step.idle     = idle_out;
		step.finished = finished;
		step.maj      = mcr_pkg::PIX_W'(maj0);
		step.mnr      = mcr_pkg::PIX_W'(min0);
		step.cx       = mcr_pkg::PIX_W'(cx0);
		step.cy       = mcr_pkg::PIX_W'(cy0);
		step.red      = red0;
		step.green    = green0;
		step.blue     = blue0;
		step.alpha    = outline0 ? alpha0 : mcr_pkg::FULL_ALPHA;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			cx_q      <= '0;
			cy_q      <= '0;
			ring_q    <= '0;
			maj_q     <= '0;
			min_q     <= '0;
			err_q     <= '0;
			red_q     <= '0;
			green_q   <= '0;
			blue_q    <= '0;
			alpha_q   <= '0;
			outline_q <= 1'b0;
		end else if (accept) begin
			if (start) begin
				cx_q      <= center_x;
				cy_q      <= center_y;
				red_q     <= red;
				green_q   <= green;
				blue_q    <= blue;
				alpha_q   <= alpha;
				outline_q <= outline_only;
			end
			if (small_fill) begin
				busy_q <= 1'b0;
				ring_q <= radius;
				maj_q  <= '0;
				min_q  <= '0;
				err_q  <= '0;
			end else if (!idle_out) begin
				busy_q <= !finished;
				if (wrap && !finished) begin
					ring_q <= rr_dec;
					maj_q  <= $signed({2'b00, rr_dec});
					min_q  <= '0;
					err_q  <= '0;
				end else begin
					ring_q <= rr0;
					maj_q  <= maj2;
					min_q  <= min1;
					err_q  <= err2;
				end
			end
		end
	end

endmodule
`default_nettype wire

### src/midpoint_circle_rasterizer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Midpoint circle rasteriser
// Draws outline or filled circles one octant step per input word, eight
// mirrored pixels per step.
// ----------------------------------------------------------------------------
// Each start or continue word is accepted and its step is worked out straight
// away; the step then leaves as eight pixel words, one per cycle while
// out_ready is high, through a single output register, and a new input word
// is taken in the cycle its predecessor's last pixel moves out. A continue
// word with no circle in progress, or a filled start with radius below two,
// gives a single word with pixel_valid low, last_of_step and circle_done
// high. Pixel coordinates wrap to 12 bits.
module midpoint_circle_rasterizer #(
	parameter int COORD_BITS  = mcr_pkg::COORD_BITS,
	parameter int RADIUS_BITS = mcr_pkg::RADIUS_BITS
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic                                mode,
	input  wire logic [COORD_BITS-1:0]               center_x,
	input  wire logic [COORD_BITS-1:0]               center_y,
	input  wire logic [RADIUS_BITS-1:0]              radius,
	input  wire logic [mcr_pkg::COLOUR_W-1:0]        red,
	input  wire logic [mcr_pkg::COLOUR_W-1:0]        green,
	input  wire logic [mcr_pkg::COLOUR_W-1:0]        blue,
	input  wire logic [mcr_pkg::COLOUR_W-1:0]        alpha,
	input  wire logic                                outline_only,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic signed [mcr_pkg::PIX_W-1:0]         pixel_x,
	output logic signed [mcr_pkg::PIX_W-1:0]         pixel_y,
	output logic [mcr_pkg::COLOUR_W-1:0]             out_red,
	output logic [mcr_pkg::COLOUR_W-1:0]             out_green,
	output logic [mcr_pkg::COLOUR_W-1:0]             out_blue,
	output logic [mcr_pkg::COLOUR_W-1:0]             out_alpha,
	output logic                                     pixel_valid,
	output logic                                     last_of_step,
	output logic                                     circle_done
);

	mcr_pkg::step_t                    step_new, step_s1;
	logic                              step_valid_s1;
	logic [mcr_pkg::MIRROR_W-1:0]      mirror_s1;

	logic                              out_valid_q;
	logic [mcr_pkg::PIX_W-1:0]         px_q, py_q;
	logic [mcr_pkg::COLOUR_W-1:0]      red_q, green_q, blue_q, alpha_q;
	logic                              pvalid_q, last_q, done_q;

	logic                              accept, load, emit, step_last, release_step;
	logic [mcr_pkg::PIX_W-1:0]         dx, dy;

	mcr_step #(
		.COORD_BITS  (COORD_BITS),
		.RADIUS_BITS (RADIUS_BITS)
	) u_step (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.mode         (mode),
		.center_x     (center_x),
		.center_y     (center_y),
		.radius       (radius),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.alpha        (alpha),
		.outline_only (outline_only),
		.step         (step_new)
	);

	always_comb begin
		load         = !out_valid_q || out_ready;
		emit         = load && step_valid_s1;
		step_last    = step_s1.idle || (mirror_s1 == mcr_pkg::MIRROR_LAST);
		release_step = emit && step_last;
		in_ready     = !step_valid_s1 || release_step;
		accept       = in_valid && in_ready;
	end

	// mirror the octant offset into the current octant
	always_comb begin
		case (mirror_s1)
			3'd0: begin dx = step_s1.maj;  dy = step_s1.mnr;  end
			3'd1: begin dx = step_s1.mnr;  dy = step_s1.maj;  end
			3'd2: begin dx = -step_s1.mnr; dy = step_s1.maj;  end
			3'd3: begin dx = -step_s1.maj; dy = step_s1.mnr;  end
			3'd4: begin dx = -step_s1.maj; dy = -step_s1.mnr; end
			3'd5: begin dx = -step_s1.mnr; dy = -step_s1.maj; end
			3'd6: begin dx = step_s1.mnr;  dy = -step_s1.maj; end
			3'd7: begin dx = step_s1.maj;  dy = -step_s1.mnr; end
			default: begin dx = '0; dy = '0; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_valid_s1 <= 1'b0;
			mirror_s1     <= '0;
		end else begin
			if (accept) begin
				step_valid_s1 <= 1'b1;
				mirror_s1     <= '0;
			end else if (release_step) begin
				step_valid_s1 <= 1'b0;
				mirror_s1     <= '0;
			end else if (emit) begin
				mirror_s1     <= mirror_s1 + mcr_pkg::MIRROR_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			step_s1 <= step_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= step_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (step_s1.idle) begin
				px_q     <= '0;
				py_q     <= '0;
				red_q    <= '0;
				green_q  <= '0;
				blue_q   <= '0;
				alpha_q  <= '0;
				pvalid_q <= 1'b0;
				last_q   <= 1'b1;
				done_q   <= 1'b1;
			end else begin
				px_q     <= step_s1.cx + dx;
				py_q     <= step_s1.cy + dy;
				red_q    <= step_s1.red;
				green_q  <= step_s1.green;
				blue_q   <= step_s1.blue;
				alpha_q  <= step_s1.alpha;
				pvalid_q <= 1'b1;
				last_q   <= step_last;
				done_q   <= step_last && step_s1.finished;
			end
		end
	end

	always_comb begin
		out_valid    = out_valid_q;
		pixel_x      = $signed(px_q);
		pixel_y      = $signed(py_q);
		out_red      = red_q;
		out_green    = green_q;
		out_blue     = blue_q;
		out_alpha    = alpha_q;
		pixel_valid  = pvalid_q;
		last_of_step = last_q;
		circle_done  = done_q;
	end

endmodule
`default_nettype wire
